// ===== rtl/osur_pkg.sv =====
// Shared types and constants for the optical sample unpack ring.
// No dependencies; imported by the ring, skid and top-level modules.
package osur_pkg;

  localparam int unsigned STORE_DEPTH_DEFAULT = 16;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned SAMPLE_W  = 18;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned PARTIAL_W = 40;  // five bytes held before the sixth arrives

  localparam logic [2:0] LAST_BYTE_POS     = 3'd5;  // sixth byte closes a record
  localparam logic [2:0] BURST_MAX_RECORDS = 3'd5;  // 30 bytes per burst

  // request kinds on the input side
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef struct packed {
    logic                stored;
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] ir;
    logic [COUNT_W-1:0]  count;
  } result_t;

endpackage

// ===== rtl/osur_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Self-contained; no package dependency.
module osur_ram #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old contents on an address collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/osur_ring.sv =====
// Record assembly, ring indexes and sample store, with one result stage.
// Depends on osur_pkg and osur_ram.
module osur_ring #(
  parameter int unsigned STORE_DEPTH = osur_pkg::STORE_DEPTH_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       kind_i,
  input  logic [osur_pkg::BYTE_W-1:0] data_byte_i,
  input  logic                       burst_start_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output osur_pkg::result_t          out_o
);
  import osur_pkg::*;

  localparam int unsigned IDX_W = $clog2(STORE_DEPTH);
  localparam int unsigned REC_W = 2 * SAMPLE_W;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(STORE_DEPTH - 1)) ? '0 : idx + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] ring_cnt(input logic [IDX_W-1:0] head,
                                                input logic [IDX_W-1:0] tail);
    logic [IDX_W:0] diff;
    diff = {1'b0, head} + ((head < tail) ? (IDX_W+1)'(STORE_DEPTH) : '0) - {1'b0, tail};
    return diff[IDX_W-1:0];
  endfunction

  logic [2:0]           pos_q, pos_d, pos_v;
  logic [PARTIAL_W-1:0] part_q, part_d, part_v;
  logic [2:0]           brec_q, brec_d, brec_v;
  logic [IDX_W-1:0]     head_q, head_d;
  logic [IDX_W-1:0]     tail_q, tail_d;
  logic                 accept;
  logic                 wr_en;
  logic [PARTIAL_W+BYTE_W-1:0] full_rec;
  logic [REC_W-1:0]     wr_data;
  logic [IDX_W-1:0]     raddr;
  logic [IDX_W-1:0]     cnt_before, cnt_after;
  logic [REC_W-1:0]     ram_rdata;

  logic                 s1_valid_q;
  logic [IDX_W-1:0]     s1_cnt_q;
  logic                 s1_stored_q;
  logic                 s1_byp_q;
  logic [REC_W-1:0]     s1_byp_data_q;
  logic [REC_W-1:0]     s1_rec;
  logic [IDX_W+COUNT_W-1:0] cnt_ext;

  assign in_ready_o = !s1_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign full_rec = {part_v, data_byte_i};
  assign wr_data  = {full_rec[SAMPLE_W+23:24], full_rec[SAMPLE_W-1:0]};

  always_comb begin
    // burst start restarts assembly before the byte is used
    if (kind_i == KIND_BYTE && burst_start_i) begin
      pos_v  = '0;
      part_v = '0;
      brec_v = '0;
    end else begin
      pos_v  = pos_q;
      part_v = part_q;
      brec_v = brec_q;
    end
    cnt_before = ring_cnt(head_q, tail_q);
    pos_d  = pos_q;
    part_d = part_q;
    brec_d = brec_q;
    head_d = head_q;
    tail_d = tail_q;
    wr_en  = 1'b0;
    if (kind_i == KIND_BYTE) begin
      pos_d  = pos_v;
      part_d = part_v;
      brec_d = brec_v;
      if (brec_v < BURST_MAX_RECORDS) begin
        if (pos_v < LAST_BYTE_POS) begin
          part_d = {part_v[PARTIAL_W-BYTE_W-1:0], data_byte_i};
          pos_d  = pos_v + 3'd1;
        end else begin
          head_d = idx_inc(head_q);
          wr_en  = 1'b1;
          pos_d  = '0;
          part_d = '0;
          brec_d = brec_v + 3'd1;
        end
      end
    end else if (kind_i == KIND_POP && cnt_before != '0) begin
      tail_d = idx_inc(tail_q);
    end
    cnt_after = ring_cnt(head_d, tail_d);
    raddr     = idx_inc(tail_d);
  end

  osur_ram #(
    .WIDTH (REC_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (accept && wr_en),
    .waddr_i (head_d),
    .wdata_i (wr_data),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      part_q     <= '0;
      brec_q     <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pos_q  <= pos_d;
        part_q <= part_d;
        brec_q <= brec_d;
        head_q <= head_d;
        tail_q <= tail_d;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cnt_q      <= cnt_after;
      s1_stored_q   <= wr_en;
      s1_byp_q      <= wr_en && (head_d == raddr);
      s1_byp_data_q <= wr_data;
    end
  end

  // same-cycle write to the read slot is forwarded
  assign s1_rec  = s1_byp_q ? s1_byp_data_q : ram_rdata;
  assign cnt_ext = {{COUNT_W{1'b0}}, s1_cnt_q};

  always_comb begin
    out_o.stored = s1_stored_q;
    out_o.count  = cnt_ext[COUNT_W-1:0];
    if (s1_cnt_q != '0) begin
      out_o.ir  = s1_rec[REC_W-1:SAMPLE_W];
      out_o.red = s1_rec[SAMPLE_W-1:0];
    end else begin
      out_o.ir  = '0;
      out_o.red = '0;
    end
  end

  assign out_valid_o = s1_valid_q;

endmodule

// ===== rtl/osur_skid.sv =====
// Two-entry skid buffer on the result side; ready toward the ring is registered.
// Depends on osur_pkg for the result type.
module osur_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  osur_pkg::result_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output osur_pkg::result_t out_data_o
);
  import osur_pkg::*;

  logic    out_valid_q, spare_valid_q;
  result_t out_data_q, spare_data_q;
  logic    accept_in, load_out;

  assign in_ready_o = !spare_valid_q;
  assign accept_in  = in_valid_i && in_ready_o;
  assign load_out   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      spare_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q   <= spare_valid_q || accept_in;
      spare_valid_q <= 1'b0;
    end else if (accept_in) begin
      spare_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= spare_valid_q ? spare_data_q : in_data_i;
    end else if (accept_in) begin
      spare_data_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/optical_sample_unpack_ring_core.sv =====
// Top level of the optical sample unpack ring: stream ports around the ring and skid.
// Depends on osur_pkg, osur_ring (with osur_ram) and osur_skid.
//
//   channel  dir  handshake               payload
//   s_axis   in   s_axis_tvalid/tready    tdata: data_byte; tuser: kind, burst_start
//   m_axis   out  m_axis_tvalid/tready    tdata: count, ir, red; tuser: record_stored
//
// One request is accepted per cycle while s_axis_tready is high; each produces exactly one result.
// Results reach m_axis through the registered store read, then the skid output
// register. A store write that lands on the slot being read is forwarded.
// Reset clears assembly state and ring indexes; the sample store is not cleared.
// A stalled m_axis fills the two-entry skid, after which s_axis_tready drops.
module optical_sample_unpack_ring_core #(
  parameter int unsigned STORE_DEPTH = osur_pkg::STORE_DEPTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [0] kind, [1] burst_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [3:0] waiting_count, [21:4] oldest_ir, [39:22] oldest_red
  output logic [0:0]  m_axis_tuser    // [0] record_stored
);
  import osur_pkg::*;

  logic    ring_valid, skid_ready;
  result_t ring_res, skid_res;

  // assembly, ring pointers, store and read stage
  osur_ring #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_ring (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .kind_i        (s_axis_tuser[0]),
    .data_byte_i   (s_axis_tdata),
    .burst_start_i (s_axis_tuser[1]),
    .out_valid_o   (ring_valid),
    .out_ready_i   (skid_ready),
    .out_o         (ring_res)
  );

  // decouples downstream ready from the input side
  osur_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ring_valid),
    .in_ready_o  (skid_ready),
    .in_data_i   (ring_res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (skid_res)
  );

  assign m_axis_tdata = {skid_res.red, skid_res.ir, skid_res.count};
  assign m_axis_tuser = skid_res.stored;

endmodule
